/* src/gar_pkg.sv */
`default_nettype none

package gar_pkg;

  // Field and register widths
  localparam int GAIN_W     = 24;  // unsigned Q8.16 gains
  localparam int FRAC_W     = 16;  // Q8.16 -> Q8.32 shift
  localparam int RAMP_W     = 40;  // unsigned Q8.32 ramp gain
  localparam int STEP_W     = 41;  // signed Q8.32 ramp step
  localparam int LEN_W      = 16;  // frame length
  localparam int CC_W       = 3;   // channel count / channel index
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LENGTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_CEIL     = 2'd2;

  // Register values after reset
  localparam logic [CC_W-1:0]   CHANNEL_COUNT_RST = 3'd2;
  localparam logic [LEN_W-1:0]  FRAME_LENGTH_RST  = 16'd1920;
  localparam logic [GAIN_W-1:0] GAIN_CEIL_RST     = 24'd655360;

  // Serial divider: one quotient bit per cycle over the Q8.32 dividend
  localparam int DIV_STEPS = RAMP_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Serial multiplier accumulator and rounding
  localparam int ACC_W     = RAMP_W + 2;
  localparam int RND_SHIFT = 32;
  localparam logic signed [ACC_W-1:0] RND_HALF = 42'sh0_8000_0000;

  // Gain limits in Q8.32
  localparam logic [RAMP_W-1:0] UNITY_Q32 = 40'h01_0000_0000;
  localparam logic [RAMP_W-1:0] RAMP_MAX  = 40'hFF_FFFF_FFFF;

  // Request to the step divider
  typedef struct packed {
    logic               start;
    logic               neg;
    logic [RAMP_W-1:0]  dividend;
    logic [LEN_W-1:0]   divisor;
  } div_req_t;

endpackage

`default_nettype wire

/* src/gar_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. Produces the signed ramp step.
module gar_div (
  input  logic                            clk,
  input  logic                            rst,
  input  gar_pkg::div_req_t               req,
  output logic                            busy,
  output logic signed [gar_pkg::STEP_W-1:0] step
);

  logic [gar_pkg::RAMP_W-1:0]    q;
  logic [gar_pkg::LEN_W-1:0]     r;
  logic [gar_pkg::LEN_W-1:0]     d;
  logic                          neg;
  logic [gar_pkg::DIV_CNT_W-1:0] cnt;

  logic [gar_pkg::LEN_W:0]       trial;
  logic                          fits;
  logic [gar_pkg::LEN_W-1:0]     r_next;
  logic [gar_pkg::RAMP_W-1:0]    q_next;
  logic [gar_pkg::STEP_W-1:0]    mag;

  // One shift-subtract step
  always_comb begin
    trial  = {r, q[gar_pkg::RAMP_W-1]};
    fits   = trial >= {1'b0, d};
    r_next = fits ? gar_pkg::LEN_W'(trial - {1'b0, d}) : trial[gar_pkg::LEN_W-1:0];
    q_next = {q[gar_pkg::RAMP_W-2:0], fits};
    mag    = {1'b0, q_next};
  end

  assign busy = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      step <= '0;
    end else if (req.start) begin
      q   <= req.dividend;
      r   <= '0;
      d   <= req.divisor;
      neg <= req.neg;
      cnt <= gar_pkg::DIV_CNT_W'(gar_pkg::DIV_STEPS);
    end else if (busy) begin
      q   <= q_next;
      r   <= r_next;
      cnt <= cnt - 1'b1;
      // last bit: publish the truncated, signed step
      if (cnt == gar_pkg::DIV_CNT_W'(1)) begin
        step <= neg ? -$signed(mag) : $signed(mag);
      end
    end
  end

endmodule

`default_nettype wire

/* src/gar_mul.sv */
`default_nettype none

// Sample-serial multiplier: one sample bit per cycle, adds the gain and shifts right.
// The accumulator starts at one half so the result comes out rounded half up.
module gar_mul #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [SAMPLE_BITS-1:0]      sample,
  input  logic [gar_pkg::RAMP_W-1:0]  gain,
  output logic                        busy,
  output logic signed [gar_pkg::ACC_W-gar_pkg::RND_SHIFT+SAMPLE_BITS-1:0] value
);

  localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

  logic signed [gar_pkg::ACC_W-1:0] acc;
  logic signed [gar_pkg::ACC_W-1:0] g_ext;
  logic signed [gar_pkg::ACC_W-1:0] addend;
  logic signed [gar_pkg::ACC_W-1:0] sum;
  logic [SAMPLE_BITS-1:0]           sh;
  logic [CNT_W-1:0]                 cnt;

  // Sign bit of the sample weighs negative
  always_comb begin
    g_ext = $signed({2'b00, gain});
    if (!sh[0]) begin
      addend = '0;
    end else if (cnt == CNT_W'(1)) begin
      addend = -g_ext;
    end else begin
      addend = g_ext;
    end
    sum = acc + addend;
  end

  assign busy  = cnt != '0;
  assign value = acc[gar_pkg::ACC_W-1:gar_pkg::RND_SHIFT-SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      acc <= gar_pkg::RND_HALF;
      sh  <= sample;
      cnt <= CNT_W'(SAMPLE_BITS);
    end else if (busy) begin
      acc <= sum >>> 1;
      sh  <= sh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* src/audio_gain_ramp_clip.sv */
// Audio gain stage with a linear per-frame gain ramp and clipping.
// Input stream s_*: one interleaved sample per word; tuser flags the first word
// of a frame and whether that frame follows the previous one. The frame's target
// gain rides in tdata and is read only on the first word of a frame.
// Output stream m_*: one gained sample per input word, tuser carries the clip flag.
// Config port: cfg_we/cfg_addr/cfg_wdata, to be written only while no word is in
// flight; the user keeps to this, and the block itself has no check for it.
// Flow: a word runs through the bit-serial multiplier; a frame's first word also
// runs the bit-serial step divider in parallel and finishes once both are done.
// s_tready rises at the edge that loads the result, so a new word is accepted
// only once the word before it has finished.
// Stall: the result sits in the output register; the next word is accepted and
// processed meanwhile, and it finishes only once the output register is free.
// Reset: registers return to their defaults, no gain is stored and the ramp is
// zero, so words before the first frame start come out as zero.
`default_nettype none

module audio_gain_ramp_clip #(
  parameter int SAMPLE_BITS   = 16,
  parameter int CHANNEL_LIMIT = 6
) (
  input  logic clk,
  input  logic rst,
  // config write port
  input  logic                             cfg_we,
  input  logic [gar_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [gar_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input stream
  input  logic s_tvalid,
  output logic s_tready,
  // sample_in, frame_gain, zero pad
  input  logic [((SAMPLE_BITS+gar_pkg::GAIN_W+7)/8)*8-1:0] s_tdata,
  // frame_start, follows_previous
  input  logic [1:0] s_tuser,
  // output stream
  output logic m_tvalid,
  input  logic m_tready,
  // sample_out, zero pad
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  // clipped
  output logic m_tuser
);

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int VAL_W = gar_pkg::ACC_W - gar_pkg::RND_SHIFT + SAMPLE_BITS;
  localparam logic signed [VAL_W-1:0] SMAX =
    $signed({{(VAL_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [VAL_W-1:0] SMIN = ~SMAX;
  localparam logic [gar_pkg::CC_W:0] MAX_CH = (gar_pkg::CC_W+1)'(CHANNEL_LIMIT);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // config registers
  logic [gar_pkg::CC_W-1:0]   channel_count;
  logic [gar_pkg::LEN_W-1:0]  frame_length;
  logic [gar_pkg::GAIN_W-1:0] gain_ceil;

  // ramp state
  logic [gar_pkg::GAIN_W-1:0] stored_gain;
  logic                       stored_gain_valid;
  logic [gar_pkg::RAMP_W-1:0] ramp_gain;
  logic [gar_pkg::CC_W-1:0]   chan_idx;
  logic                       state;

  logic [SAMPLE_BITS-1:0]     out_sample;

  // input fields
  logic [SAMPLE_BITS-1:0]     sample_in;
  logic [gar_pkg::GAIN_W-1:0] frame_gain;
  logic                       frame_start;
  logic                       follows_previous;
  logic                       accept;

  // frame start setup
  logic [gar_pkg::GAIN_W-1:0] target;
  logic [gar_pkg::GAIN_W-1:0] prev;
  logic                       down;
  logic [gar_pkg::GAIN_W-1:0] mag;
  gar_pkg::div_req_t          div_req;

  // serial units
  logic                                div_busy;
  logic signed [gar_pkg::STEP_W-1:0]   ramp_step;
  logic                                mul_busy;
  logic signed [VAL_W-1:0]             value;

  // finish
  logic                          finish;
  logic                          above_unity;
  logic                          over;
  logic                          under;
  logic [SAMPLE_BITS-1:0]        sample_next;
  logic signed [gar_pkg::ACC_W-1:0] ramp_sum;
  logic [gar_pkg::RAMP_W-1:0]    ramp_next;
  logic [gar_pkg::CC_W:0]        chans;
  logic [gar_pkg::CC_W-1:0]      idx_inc;
  logic                          group_end;

  assign sample_in        = s_tdata[SAMPLE_BITS-1:0];
  assign frame_gain       = s_tdata[SAMPLE_BITS+gar_pkg::GAIN_W-1:SAMPLE_BITS];
  assign frame_start      = s_tuser[0];
  assign follows_previous = s_tuser[1];

  assign s_tready = state == ST_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = OUT_W'(out_sample);

  // Target capping and ramp start point
  always_comb begin
    target = (gain_ceil != '0 && frame_gain > gain_ceil) ? gain_ceil : frame_gain;
    prev   = (!stored_gain_valid || !follows_previous) ? target : stored_gain;
    down   = target < prev;
    mag    = down ? prev - target : target - prev;
    div_req.start    = accept && frame_start;
    div_req.neg      = down;
    div_req.dividend = {mag, {gar_pkg::FRAC_W{1'b0}}};
    div_req.divisor  = (frame_length == '0) ? gar_pkg::LEN_W'(1) : frame_length;
  end

  gar_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .step (ramp_step)
  );

  gar_mul #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .sample (sample_in),
    .gain   (ramp_gain),
    .busy   (mul_busy),
    .value  (value)
  );

  // Saturation, ramp advance and channel group tracking
  always_comb begin
    finish      = (state == ST_RUN) && !mul_busy && !div_busy && (!m_tvalid || m_tready);
    above_unity = ramp_gain > gar_pkg::UNITY_Q32;
    over        = above_unity && (value > SMAX);
    under       = above_unity && (value < SMIN);
    priority if (over) begin
      sample_next = SMAX[SAMPLE_BITS-1:0];
    end else if (under) begin
      sample_next = SMIN[SAMPLE_BITS-1:0];
    end else begin
      sample_next = value[SAMPLE_BITS-1:0];
    end

    ramp_sum = $signed({2'b00, ramp_gain}) + $signed({ramp_step[gar_pkg::STEP_W-1], ramp_step});
    priority if (ramp_sum[gar_pkg::ACC_W-1]) begin
      ramp_next = '0;
    end else if (ramp_sum[gar_pkg::ACC_W-2]) begin
      ramp_next = gar_pkg::RAMP_MAX;
    end else begin
      ramp_next = ramp_sum[gar_pkg::RAMP_W-1:0];
    end

    chans = (channel_count == '0) ? (gar_pkg::CC_W+1)'(1) : {1'b0, channel_count};
    if (chans > MAX_CH) begin
      chans = MAX_CH;
    end
    idx_inc   = chan_idx + 1'b1;
    group_end = {1'b0, idx_inc} >= chans;
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= gar_pkg::CHANNEL_COUNT_RST;
      frame_length  <= gar_pkg::FRAME_LENGTH_RST;
      gain_ceil     <= gar_pkg::GAIN_CEIL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gar_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_wdata[gar_pkg::CC_W-1:0];
        gar_pkg::REG_FRAME_LENGTH:  frame_length  <= cfg_wdata[gar_pkg::LEN_W-1:0];
        gar_pkg::REG_GAIN_CEIL:     gain_ceil     <= cfg_wdata[gar_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and ramp state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      stored_gain       <= '0;
      stored_gain_valid <= 1'b0;
      ramp_gain         <= '0;
      chan_idx          <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      // output valid: set by a finishing word, cleared once taken
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        state <= ST_RUN;
        if (frame_start) begin
          ramp_gain         <= {prev, {gar_pkg::FRAC_W{1'b0}}};
          stored_gain       <= target;
          stored_gain_valid <= 1'b1;
          chan_idx          <= '0;
        end
      end else if (finish) begin
        state <= ST_IDLE;
        if (group_end) begin
          chan_idx  <= '0;
          ramp_gain <= ramp_next;
        end else begin
          chan_idx <= idx_inc;
        end
      end
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (finish) begin
      out_sample <= sample_next;
      m_tuser    <= over || under;
    end
  end

  // A word in flight blocks the input until it finishes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input ready right after accepting a word");

  // The ramp gain only moves at frame start or at the end of a word
  a_ramp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && !finish) |=> $stable(ramp_gain))
    else $error("ramp gain changed mid-word");

  // Once a gain is stored it stays stored
  a_gain_kept: assert property (@(posedge clk) disable iff (rst)
    !$fell(stored_gain_valid))
    else $error("stored gain lost");

  // The divider runs only for frame-start words
  a_div_frame_only: assert property (@(posedge clk) disable iff (rst)
    (accept && !frame_start) |=> !div_busy)
    else $error("divider busy on a word inside a frame");

endmodule

`default_nettype wire

/* sim/tb_audio_gain_ramp_clip.sv */
`timescale 1ns / 1ps

module tb_audio_gain_ramp_clip;

  // input word as handed to the driver
  typedef struct {
    logic [15:0]                smp;
    logic [gar_pkg::GAIN_W-1:0] gain;
    bit                         fs;
    bit                         fp;
  } in_word_t;

  // predicted output word
  typedef struct {
    logic [15:0] smp;
    bit          clip;
  } gained_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_we    = 1'b0;
  logic [gar_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [gar_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;  // sample_in, frame_gain
  logic [1:0]  s_tuser  = '0;  // frame_start, follows_previous
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // sample_out
  logic        m_tuser;        // clipped

  audio_gain_ramp_clip u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_word_t pend_q[$];
  gained_t  gained_q[$];
  in_word_t drv_w;
  gained_t  got_w;

  int send_idle = 0;
  int recv_idle = 0;
  int stall_ask = 0;
  int stall_seen;
  int hold_cnt;

  int errors     = 0;
  int words_in   = 0;
  int words_out  = 0;
  int clip_cnt   = 0;
  int frame_cnt  = 0;
  int reg_writes = 0;

  // register copies
  logic [gar_pkg::CC_W-1:0]   cc_reg  = gar_pkg::CHANNEL_COUNT_RST;
  logic [gar_pkg::LEN_W-1:0]  len_reg = gar_pkg::FRAME_LENGTH_RST;
  logic [gar_pkg::GAIN_W-1:0] max_reg = gar_pkg::GAIN_CEIL_RST;

  // gain state
  logic [gar_pkg::GAIN_W-1:0] held_gain  = '0;
  bit                         held_valid = 1'b0;
  logic [gar_pkg::RAMP_W-1:0] ramp       = '0;
  longint                     ramp_inc   = 0;
  int                         grp_pos    = 0;

  // Gain one sample, advance the ramp, queue the expected word
  function automatic void gain_sample(logic signed [15:0] smp, bit fs,
                                      logic [gar_pkg::GAIN_W-1:0] fgain, bit fp);
    logic [gar_pkg::GAIN_W-1:0] tgt;
    longint                     len;
    longint                     diff;
    longint                     acc;
    longint                     nxt;
    int                         chans;
    gained_t                    g;
    if (fs) begin
      tgt = fgain;
      len = (len_reg == 0) ? 1 : longint'(len_reg);
      if (max_reg != 0 && tgt > max_reg) tgt = max_reg;
      if (!held_valid || !fp) held_gain = tgt;
      diff = longint'(tgt) - longint'(held_gain);
      ramp = {held_gain, 16'h0};
      if (diff >= 0) ramp_inc = (diff <<< 16) / len;
      else ramp_inc = -(((-diff) <<< 16) / len);
      held_gain  = tgt;
      held_valid = 1'b1;
      grp_pos    = 0;
      frame_cnt++;
    end
    // exact product, round half up by floor(p + 0.5)
    acc = longint'(smp) * longint'(ramp) + (64'sd1 <<< 31);
    acc = acc >>> 32;
    g.clip = 1'b0;
    if (ramp > gar_pkg::UNITY_Q32) begin
      if (acc > 32767) begin
        acc = 32767;
        g.clip = 1'b1;
      end else if (acc < -32768) begin
        acc = -32768;
        g.clip = 1'b1;
      end
    end
    g.smp = acc[15:0];
    gained_q.push_back(g);
    // one ramp step per channel group
    chans = (cc_reg == 0) ? 1 : ((cc_reg > 6) ? 6 : int'(cc_reg));
    grp_pos = (grp_pos + 1) & 7;
    if (grp_pos >= chans) begin
      grp_pos = 0;
      nxt = longint'(ramp) + ramp_inc;
      if (nxt < 0) nxt = 0;
      if (nxt > longint'(gar_pkg::RAMP_MAX)) nxt = longint'(gar_pkg::RAMP_MAX);
      ramp = nxt[gar_pkg::RAMP_W-1:0];
    end
  endfunction

  // Driver: next pending word, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        drv_w = pend_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {drv_w.gain, drv_w.smp};
        s_tuser  <= {drv_w.fp, drv_w.fs};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Predict on every accepted input word
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      gain_sample(s_tdata[15:0], s_tuser[0], s_tdata[39:16], s_tuser[1]);
      words_in++;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      hold_cnt   <= 0;
      stall_seen <= 0;
    end else if (stall_seen != stall_ask) begin
      stall_seen <= stall_ask;
      hold_cnt   <= 400;
      m_tready   <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: compare each output word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      words_out++;
      if (gained_q.size() == 0) begin
        errors++;
        $display("%0t: output word with none expected: sample %0d clipped %0b",
                 $time, $signed(m_tdata), m_tuser);
      end else begin
        got_w = gained_q.pop_front();
        if (got_w.clip) clip_cnt++;
        if (m_tdata !== got_w.smp) begin
          errors++;
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, $signed(got_w.smp), $signed(m_tdata));
        end
        if (m_tuser !== got_w.clip) begin
          errors++;
          $display("%0t: clipped mismatch: expected %0b, actual %0b",
                   $time, got_w.clip, m_tuser);
        end
      end
    end
  end

  task automatic push_word(logic [15:0] smp, bit fs, logic [gar_pkg::GAIN_W-1:0] gain,
                           bit fp);
    in_word_t w;
    w.smp  = smp;
    w.fs   = fs;
    w.gain = gain;
    w.fp   = fp;
    pend_q.push_back(w);
  endtask

  task automatic set_reg(logic [gar_pkg::CFG_ADDR_W-1:0] idx,
                         logic [gar_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      gar_pkg::REG_CHANNEL_COUNT: cc_reg  = val[gar_pkg::CC_W-1:0];
      gar_pkg::REG_FRAME_LENGTH:  len_reg = val[gar_pkg::LEN_W-1:0];
      gar_pkg::REG_GAIN_CEIL:     max_reg = val[gar_pkg::GAIN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every pending word is sent and every expected word is out, then let the pipe settle
  task automatic drain();
    while (pend_q.size() != 0 || s_tvalid || gained_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(3)) - 16'd1;  // small values around zero
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [gar_pkg::GAIN_W-1:0] rand_gain();
    case ($urandom_range(5))
      0: return 24'($urandom_range(0, 65536));
      1: return 24'(65536 + $urandom_range(0, 3 * 65536));
      2: begin
        case ($urandom_range(4))
          0: return 24'h0;
          1: return 24'h010000;
          2: return 24'hFFFFFF;
          3: return max_reg;
          default: return max_reg + 24'd1;
        endcase
      end
      default: return 24'($urandom);
    endcase
  endfunction

  // Random frames: mostly well-formed runs, some restarts and stray words
  task automatic random_frames(int n);
    int cnt;
    int flen;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(9) == 0) begin
        push_word(rand_sample(), 1'b0, 24'($urandom), 1'($urandom));
        cnt++;
      end else begin
        flen = ($urandom_range(4) == 0) ? 1 : $urandom_range(2, 20);
        push_word(rand_sample(), 1'b1, rand_gain(), $urandom_range(4) != 0);
        for (int i = 1; i < flen; i++)
          push_word(rand_sample(), 1'b0, 24'($urandom), 1'($urandom));
        cnt += flen;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: sender idles 15%, receiver 82%, default registers
    send_idle = 15;
    recv_idle = 82;
    // before any frame start the gain is zero
    push_word(16'h7FFF, 1'b0, 24'hFFFFFF, 1'b1);
    push_word(16'h8000, 1'b0, 24'hFFFFFF, 1'b1);
    // unity gain, no stored gain yet so the ramp starts at the target
    push_word(16'h7FFF, 1'b1, 24'h010000, 1'b1);
    push_word(16'h8000, 1'b0, 24'h0, 1'b0);
    push_word(16'h0001, 1'b0, 24'h0, 1'b0);
    push_word(16'hFFFF, 1'b0, 24'h0, 1'b0);
    // full-scale target capped to the ceiling, ramp from unity, clipping
    push_word(16'h7FFF, 1'b1, 24'hFFFFFF, 1'b1);
    push_word(16'h8000, 1'b0, 24'h0, 1'b0);
    push_word(16'h7FFF, 1'b0, 24'h0, 1'b0);
    push_word(16'h3039, 1'b0, 24'h0, 1'b0);
    push_word(16'hFFFF, 1'b0, 24'h0, 1'b0);
    // zero gain, frame does not follow
    push_word(16'h7FFF, 1'b1, 24'h0, 1'b0);
    push_word(16'h8000, 1'b0, 24'h0, 1'b0);
    // just under unity: no saturation applied
    push_word(16'h7FFF, 1'b1, 24'h00FFFF, 1'b0);
    push_word(16'h8000, 1'b0, 24'h0, 1'b0);
    push_word(16'h0001, 1'b0, 24'h0, 1'b0);
    push_word(16'hFFFF, 1'b0, 24'h0, 1'b0);
    // half gain: rounding of exact halves
    push_word(16'h0001, 1'b1, 24'h008000, 1'b0);
    push_word(16'hFFFF, 1'b0, 24'h0, 1'b0);
    push_word(16'h0003, 1'b0, 24'h0, 1'b0);
    push_word(16'hFFFD, 1'b0, 24'h0, 1'b0);
    // ramp up from half to double
    push_word(16'h4E20, 1'b1, 24'h020000, 1'b1);
    push_word(16'hB1E0, 1'b0, 24'h0, 1'b0);
    drain();

    // one channel, one-group frames, no ceiling: ramp overruns to the top
    set_reg(gar_pkg::REG_CHANNEL_COUNT, 24'd1);
    set_reg(gar_pkg::REG_FRAME_LENGTH, 24'd1);
    set_reg(gar_pkg::REG_GAIN_CEIL, 24'd0);
    @(negedge clk);
    random_frames(105);
    drain();

    // sender idles 82%, receiver 15%; widest settings
    send_idle = 82;
    recv_idle = 15;
    set_reg(gar_pkg::REG_CHANNEL_COUNT, 24'd6);
    set_reg(gar_pkg::REG_FRAME_LENGTH, 24'd65535);
    set_reg(gar_pkg::REG_GAIN_CEIL, 24'hFFFFFF);
    @(negedge clk);
    random_frames(105);
    drain();

    // zero channel count and length read as one; ceiling at unity
    set_reg(gar_pkg::REG_CHANNEL_COUNT, 24'd0);
    set_reg(gar_pkg::REG_FRAME_LENGTH, 24'd0);
    set_reg(gar_pkg::REG_GAIN_CEIL, 24'h010000);
    @(negedge clk);
    stall_ask++;  // long receiver hold-off while the sender keeps offering
    random_frames(105);
    drain();

    // no idling on either side
    send_idle = 0;
    recv_idle = 0;
    set_reg(gar_pkg::REG_CHANNEL_COUNT, 24'd7);
    set_reg(gar_pkg::REG_FRAME_LENGTH, 24'd3);
    set_reg(gar_pkg::REG_GAIN_CEIL, 24'($urandom_range(65537, 24'hFFFFFF)));
    @(negedge clk);
    random_frames(105);
    drain();

    set_reg(gar_pkg::REG_CHANNEL_COUNT, 24'd3);
    set_reg(gar_pkg::REG_FRAME_LENGTH, 24'd4);
    set_reg(gar_pkg::REG_GAIN_CEIL, 24'd0);
    @(negedge clk);
    random_frames(105);
    drain();

    $display("Covered %0d input words in %0d frames over %0d register writes,",
             words_in, frame_cnt, reg_writes);
    $display("%0d output words checked, %0d of them saturated.", words_out, clip_cnt);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
